// ===== hw/rtl/dcs_pkg.sv =====
package dcs_pkg;

  // element and accumulator widths
  localparam int EL_BITS   = 16;
  localparam int DOT_BITS  = 43;
  localparam int SQ_BITS   = 41;
  localparam int PROD_BITS = 2 * EL_BITS;

  // serial products of the accumulators
  localparam int PP_BITS   = 2 * SQ_BITS;
  localparam int DD_BITS   = 2 * DOT_BITS;
  localparam int MUL_STEPS = DOT_BITS;
  localparam int CNT_BITS  = $clog2(MUL_STEPS);

  // result and root search
  localparam int Q_BITS    = 16;
  localparam int ROOT_BITS = 120;
  localparam logic signed [Q_BITS-1:0] COS_MAX = {1'b0, {(Q_BITS-1){1'b1}}};

  typedef enum logic [3:0] {
    S_ACC,
    S_FOLD,
    S_LOAD,
    S_MUL,
    S_PREP,
    S_RA,
    S_RB,
    S_RC,
    S_DONE
  } state_t;

  typedef struct packed {
    logic take;
    logic load;
    logic mul_step;
    logic prep;
    logic ph_a;
    logic ph_b;
    logic ph_c;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic bit_last;
    logic out_full;
  } stat_t;

endpackage

// ===== hw/rtl/dcs_ctrl.sv =====
module dcs_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           last,
  input  dcs_pkg::stat_t stat,
  output logic           in_ready,
  output dcs_pkg::cmd_t  cmd
);

  dcs_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dcs_pkg::S_ACC;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      dcs_pkg::S_ACC: begin
        if (in_valid && last) state_next = dcs_pkg::S_FOLD;
      end
      dcs_pkg::S_FOLD: state_next = dcs_pkg::S_LOAD;
      dcs_pkg::S_LOAD: state_next = dcs_pkg::S_MUL;
      dcs_pkg::S_MUL: begin
        if (stat.mul_done) state_next = dcs_pkg::S_PREP;
      end
      dcs_pkg::S_PREP: state_next = dcs_pkg::S_RA;
      dcs_pkg::S_RA:   state_next = dcs_pkg::S_RB;
      dcs_pkg::S_RB:   state_next = dcs_pkg::S_RC;
      dcs_pkg::S_RC: begin
        state_next = stat.bit_last ? dcs_pkg::S_DONE : dcs_pkg::S_RA;
      end
      dcs_pkg::S_DONE: begin
        if (!stat.out_full) state_next = dcs_pkg::S_ACC;
      end
      default: state_next = dcs_pkg::S_ACC;
    endcase
  end

  always_comb begin
    in_ready     = (state == dcs_pkg::S_ACC);
    cmd          = '0;
    cmd.take     = in_valid && in_ready;
    cmd.load     = (state == dcs_pkg::S_LOAD);
    cmd.mul_step = (state == dcs_pkg::S_MUL);
    cmd.prep     = (state == dcs_pkg::S_PREP);
    cmd.ph_a     = (state == dcs_pkg::S_RA);
    cmd.ph_b     = (state == dcs_pkg::S_RB);
    cmd.ph_c     = (state == dcs_pkg::S_RC);
    cmd.out_load = (state == dcs_pkg::S_DONE) && !stat.out_full;
  end

endmodule

// ===== hw/rtl/dcs_datapath.sv =====
module dcs_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  dcs_pkg::cmd_t                       cmd,
  input  logic signed [dcs_pkg::EL_BITS-1:0]  v_element,
  input  logic signed [dcs_pkg::EL_BITS-1:0]  w_element,
  input  logic                                out_ready,
  output dcs_pkg::stat_t                      stat,
  output logic                                out_valid,
  output logic signed [dcs_pkg::Q_BITS-1:0]   cosine,
  output logic                                zero_magnitude
);

  // product stage
  logic signed [dcs_pkg::PROD_BITS-1:0] prod_vw;
  logic        [dcs_pkg::PROD_BITS-1:0] prod_vv;
  logic        [dcs_pkg::PROD_BITS-1:0] prod_ww;
  logic                                 pipe_valid;

  // accumulators
  logic signed [dcs_pkg::DOT_BITS-1:0] dot_acc;
  logic        [dcs_pkg::SQ_BITS-1:0]  vv_acc;
  logic        [dcs_pkg::SQ_BITS-1:0]  ww_acc;
  logic signed [dcs_pkg::DOT_BITS:0]   dot_sum;
  logic        [dcs_pkg::SQ_BITS:0]    vv_sum;
  logic        [dcs_pkg::SQ_BITS:0]    ww_sum;
  logic signed [dcs_pkg::DOT_BITS-1:0] dot_sat;
  logic        [dcs_pkg::SQ_BITS-1:0]  vv_sat;
  logic        [dcs_pkg::SQ_BITS-1:0]  ww_sat;
  logic        [dcs_pkg::DOT_BITS-1:0] dot_mag;

  // shift-add multipliers
  logic [dcs_pkg::PP_BITS-1:0]  mc_v;
  logic [dcs_pkg::SQ_BITS-1:0]  mp_w;
  logic [dcs_pkg::PP_BITS-1:0]  pp;
  logic [dcs_pkg::DD_BITS-1:0]  mc_d;
  logic [dcs_pkg::DOT_BITS-1:0] mp_d;
  logic [dcs_pkg::DD_BITS-1:0]  dd;
  logic [dcs_pkg::CNT_BITS-1:0] cnt;
  logic                         neg;
  logic                         zero;

  // root search, one result bit per pass through phases a, b and c
  logic signed [dcs_pkg::ROOT_BITS-1:0] l_reg;
  logic signed [dcs_pkg::ROOT_BITS-1:0] ms;
  logic signed [dcs_pkg::ROOT_BITS-1:0] ps;
  logic signed [dcs_pkg::ROOT_BITS-1:0] r_val;
  logic signed [dcs_pkg::ROOT_BITS-1:0] tmp;
  logic signed [dcs_pkg::ROOT_BITS-1:0] cand;
  logic signed [dcs_pkg::ROOT_BITS-1:0] ms_upd;
  logic        [dcs_pkg::Q_BITS-1:0]    q;
  logic        [dcs_pkg::Q_BITS-1:0]    bmask;
  logic                                 accept;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      prod_vw <= dcs_pkg::PROD_BITS'(v_element) * dcs_pkg::PROD_BITS'(w_element);
      prod_vv <= $unsigned(dcs_pkg::PROD_BITS'(v_element) * dcs_pkg::PROD_BITS'(v_element));
      prod_ww <= $unsigned(dcs_pkg::PROD_BITS'(w_element) * dcs_pkg::PROD_BITS'(w_element));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= 1'b0;
    end else begin
      pipe_valid <= cmd.take;
    end
  end

  always_comb begin
    dot_sum = (dcs_pkg::DOT_BITS+1)'(dot_acc) + (dcs_pkg::DOT_BITS+1)'(prod_vw);
    vv_sum  = (dcs_pkg::SQ_BITS+1)'(vv_acc) + (dcs_pkg::SQ_BITS+1)'(prod_vv);
    ww_sum  = (dcs_pkg::SQ_BITS+1)'(ww_acc) + (dcs_pkg::SQ_BITS+1)'(prod_ww);
    if (dot_sum[dcs_pkg::DOT_BITS] != dot_sum[dcs_pkg::DOT_BITS-1]) begin
      dot_sat = dot_sum[dcs_pkg::DOT_BITS] ? {1'b1, {(dcs_pkg::DOT_BITS-1){1'b0}}}
                                          : {1'b0, {(dcs_pkg::DOT_BITS-1){1'b1}}};
    end else begin
      dot_sat = dot_sum[dcs_pkg::DOT_BITS-1:0];
    end
    vv_sat  = vv_sum[dcs_pkg::SQ_BITS] ? '1 : vv_sum[dcs_pkg::SQ_BITS-1:0];
    ww_sat  = ww_sum[dcs_pkg::SQ_BITS] ? '1 : ww_sum[dcs_pkg::SQ_BITS-1:0];
    dot_mag = dot_acc[dcs_pkg::DOT_BITS-1] ? dcs_pkg::DOT_BITS'(-dot_acc) : dot_acc;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      dot_acc <= '0;
      vv_acc  <= '0;
      ww_acc  <= '0;
    end else if (pipe_valid) begin
      dot_acc <= dot_sat;
      vv_acc  <= vv_sat;
      ww_acc  <= ww_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mc_v <= dcs_pkg::PP_BITS'(vv_acc);
      mp_w <= ww_acc;
      mc_d <= dcs_pkg::DD_BITS'(dot_mag);
      mp_d <= dot_mag;
      pp   <= '0;
      dd   <= '0;
      cnt  <= '0;
      neg  <= dot_acc[dcs_pkg::DOT_BITS-1];
      zero <= (vv_acc == '0) || (ww_acc == '0);
    end else if (cmd.mul_step) begin
      if (mp_w[0]) pp <= pp + mc_v;
      if (mp_d[0]) dd <= dd + mc_d;
      mc_v <= mc_v << 1;
      mp_w <= mp_w >> 1;
      mc_d <= mc_d << 1;
      mp_d <= mp_d >> 1;
      cnt  <= cnt + 1'b1;
    end
  end

  // l_reg holds (2q-1)^2*p, ms holds (2q-1)*p and ps holds p, both aligned to the bit under test
  always_comb begin
    accept = !q[dcs_pkg::Q_BITS-1] && (cand <= r_val);
    ms_upd = accept ? ms + (ps <<< 1) : ms;
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      l_reg <= dcs_pkg::ROOT_BITS'(pp);
      ms    <= -(dcs_pkg::ROOT_BITS'(pp) << (dcs_pkg::Q_BITS + 1));
      ps    <= dcs_pkg::ROOT_BITS'(pp) << (2 * dcs_pkg::Q_BITS);
      r_val <= dcs_pkg::ROOT_BITS'(dd) << (2 * dcs_pkg::Q_BITS);
      q     <= '0;
      bmask <= {1'b1, {(dcs_pkg::Q_BITS-1){1'b0}}};
    end else if (cmd.ph_a) begin
      tmp <= l_reg + ms;
    end else if (cmd.ph_b) begin
      cand <= tmp + ps;
    end else if (cmd.ph_c) begin
      if (accept) begin
        l_reg <= cand;
        q     <= q | bmask;
      end
      ms    <= ms_upd >>> 1;
      ps    <= ps >>> 2;
      bmask <= bmask >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      zero_magnitude <= zero;
      if (zero) begin
        cosine <= '0;
      end else if (neg) begin
        cosine <= -q;
      end else begin
        cosine <= q[dcs_pkg::Q_BITS-1] ? dcs_pkg::COS_MAX : q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    stat.mul_done = (cnt == dcs_pkg::CNT_BITS'(dcs_pkg::MUL_STEPS - 1));
    stat.bit_last = bmask[0];
    stat.out_full = out_valid && !out_ready;
  end

endmodule

// ===== hw/rtl/dense_cosine_similarity.sv =====
// element pairs are taken one per cycle while intake is open, each word folded into the
// sums in the cycle after it is taken; a word with last set stops intake, and its result
// then passes through fold, load, the shift-add products, setup, the root search and output
// a result still waiting to be taken holds the next one in the final state, and intake
// resumes once it is registered; synchronous reset clears the sums, the controller and
// the output valid
module dense_cosine_similarity (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [dcs_pkg::EL_BITS-1:0]  v_element,
  input  logic signed [dcs_pkg::EL_BITS-1:0]  w_element,
  input  logic                                last,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [dcs_pkg::Q_BITS-1:0]   cosine,
  output logic                                zero_magnitude
);

  dcs_pkg::cmd_t  cmd;
  dcs_pkg::stat_t stat;

  dcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .last     (last),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  dcs_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .v_element      (v_element),
    .w_element      (w_element),
    .out_ready      (out_ready),
    .stat           (stat),
    .out_valid      (out_valid),
    .cosine         (cosine),
    .zero_magnitude (zero_magnitude)
  );

endmodule

// ===== hw/rtl/dcs_checker.sv =====
module dcs_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              last,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [dcs_pkg::Q_BITS-1:0] cosine,
  input logic                              zero_magnitude
);

  // a waiting result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cosine) && $stable(zero_magnitude))
    else $error("result word changed while stalled");

  a_zero_cos: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_magnitude |-> cosine == '0)
    else $error("zero magnitude with non-zero cosine");

  // intake stops once the final pair is taken
  a_last_stop: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last |=> !in_ready)
    else $error("intake open after final pair");

  // a new result only appears after a stretch with intake closed
  a_rise_closed: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while intake open");

endmodule

bind dense_cosine_similarity dcs_checker u_chk (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .last           (last),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .cosine         (cosine),
  .zero_magnitude (zero_magnitude)
);

// ===== dv/tb_dense_cosine_similarity.sv =====
module tb_dense_cosine_similarity;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 200;

  typedef logic signed [dcs_pkg::EL_BITS-1:0] elem_t;
  typedef longint unsigned u64_t;

  typedef struct packed {
    logic signed [dcs_pkg::Q_BITS-1:0] cosine;
    logic                              zero_mag;
  } cos_result_t;

  localparam longint DOT_HI = (64'sd1 <<< (dcs_pkg::DOT_BITS - 1)) - 64'sd1;
  localparam longint DOT_LO = -(64'sd1 <<< (dcs_pkg::DOT_BITS - 1));
  localparam u64_t   SQ_HI  = (64'd1 << dcs_pkg::SQ_BITS) - 64'd1;
  localparam logic signed [dcs_pkg::Q_BITS-1:0] COS_MIN = {1'b1, {(dcs_pkg::Q_BITS-1){1'b0}}};

  logic  clk       = 1'b0;
  logic  rst       = 1'b1;
  logic  in_valid  = 1'b0;
  elem_t v_element = '0;
  elem_t w_element = '0;
  logic  last      = 1'b0;
  logic  out_ready = 1'b0;
  logic  in_ready;
  logic  out_valid;
  logic signed [dcs_pkg::Q_BITS-1:0] cosine;
  logic  zero_magnitude;

  dense_cosine_similarity dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .v_element      (v_element),
    .w_element      (w_element),
    .last           (last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .cosine         (cosine),
    .zero_magnitude (zero_magnitude)
  );

  always #1 clk = ~clk;

  // running sums of the vectors being streamed in
  logic signed [dcs_pkg::DOT_BITS-1:0] dot_sum = '0;
  logic [dcs_pkg::SQ_BITS-1:0]         v_energy = '0;
  logic [dcs_pkg::SQ_BITS-1:0]         w_energy = '0;

  cos_result_t pending_cosines[$];
  elem_t       v_words[$];
  elem_t       w_words[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches    = 0;
  int words_sent    = 0;
  int vectors_sent  = 0;
  int cosines_seen  = 0;
  int zero_results  = 0;
  int full_scale    = 0;
  int cycle_count   = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d cosines outstanding",
               cycle_count, pending_cosines.size());
      $display("dense_cosine_similarity verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= !rst && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    $display("MISMATCH cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
  endtask

  always @(posedge clk) begin : check_result
    cos_result_t want;
    if (!rst && out_valid && out_ready) begin
      cosines_seen++;
      if (pending_cosines.size() == 0) begin
        report_mismatch("unexpected result, cosine", int'(cosine), 0);
      end else begin
        want = pending_cosines.pop_front();
        if (cosine !== want.cosine)
          report_mismatch("cosine", int'(cosine), int'(want.cosine));
        if (zero_magnitude !== want.zero_mag)
          report_mismatch("zero_magnitude", int'(zero_magnitude), int'(want.zero_mag));
      end
    end
  end

  // rounded |dot| / sqrt(|v|^2 |w|^2) in Q1.15, found bit by bit by exact comparison
  function automatic cos_result_t angle_of_sums();
    logic [127:0] energy, bound, odd, lhs, mag;
    logic [16:0]  q, t;
    longint       dot_abs;
    cos_result_t  r;
    r.cosine   = '0;
    r.zero_mag = 1'b1;
    if (v_energy == 0 || w_energy == 0)
      return r;
    dot_abs = (dot_sum < 0) ? -longint'(dot_sum) : longint'(dot_sum);
    mag     = 128'(dot_abs);
    energy  = 128'(v_energy) * 128'(w_energy);
    bound   = (mag * mag) << 32;
    q = '0;
    for (int b = 15; b >= 0; b--) begin
      t = q | (17'd1 << b);
      if (t <= 17'd32768) begin
        odd = 2 * 128'(t) - 1;
        lhs = odd * odd * energy;
        if (lhs <= bound)
          q = t;
      end
    end
    r.zero_mag = 1'b0;
    if (dot_sum < 0)
      r.cosine = dcs_pkg::Q_BITS'(-int'(q));
    else
      r.cosine = (q > 17'd32767) ? dcs_pkg::COS_MAX : dcs_pkg::Q_BITS'(q);
    return r;
  endfunction

  task automatic fold_pair(elem_t v, elem_t w, logic l);
    longint      d;
    u64_t        s;
    cos_result_t r;
    d = longint'(dot_sum) + longint'(v) * longint'(w);
    if (d > DOT_HI) d = DOT_HI;
    if (d < DOT_LO) d = DOT_LO;
    dot_sum = dcs_pkg::DOT_BITS'(d);
    s = u64_t'(v_energy) + u64_t'(longint'(v) * longint'(v));
    v_energy = dcs_pkg::SQ_BITS'((s > SQ_HI) ? SQ_HI : s);
    s = u64_t'(w_energy) + u64_t'(longint'(w) * longint'(w));
    w_energy = dcs_pkg::SQ_BITS'((s > SQ_HI) ? SQ_HI : s);
    if (l) begin
      r = angle_of_sums();
      pending_cosines = {pending_cosines, r};
      if (r.zero_mag) zero_results++;
      if (r.cosine == dcs_pkg::COS_MAX || r.cosine == COS_MIN) full_scale++;
      dot_sum  = '0;
      v_energy = '0;
      w_energy = '0;
    end
  endtask

  task automatic send_pair(elem_t v, elem_t w, logic l);
    if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    v_element <= v;
    w_element <= w;
    last      <= l;
    do @(posedge clk); while (!in_ready);
    fold_pair(v, w, l);
    words_sent++;
  endtask

  // hold off intake until every cosine in flight has been taken
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_cosines.size() != 0);
  endtask

  task automatic add_pair(elem_t v, elem_t w);
    v_words = {v_words, v};
    w_words = {w_words, w};
  endtask

  task automatic send_vectors();
    for (int i = 0; i < v_words.size(); i++)
      send_pair(v_words[i], w_words[i], i == v_words.size() - 1);
    v_words.delete();
    w_words.delete();
    vectors_sent++;
  endtask

  function automatic elem_t random_element(int style);
    case (style)
      0: return elem_t'($urandom);
      1: return elem_t'(int'($urandom_range(0, 6)) - 3);
      2: begin
        case ($urandom_range(0, 4))
          0: return elem_t'(-32768);
          1: return elem_t'(32767);
          2: return elem_t'(-1);
          3: return elem_t'(1);
          default: return elem_t'(0);
        endcase
      end
      default: return elem_t'(0);
    endcase
  endfunction

  // one-element vectors: always full scale either way, or zero magnitude
  task automatic test_single_element_vectors();
    elem_t pv[9] = '{elem_t'(32767), elem_t'(-32768), elem_t'(-32768), elem_t'(32767),
                     elem_t'(1), elem_t'(1), elem_t'(0), elem_t'(0), elem_t'(-1)};
    elem_t pw[9] = '{elem_t'(32767), elem_t'(-32768), elem_t'(32767), elem_t'(-32768),
                     elem_t'(1), elem_t'(-1), elem_t'(0), elem_t'(-32768), elem_t'(0)};
    for (int i = 0; i < 9; i++) begin
      add_pair(pv[i], pw[i]);
      send_vectors();
    end
  endtask

  task automatic test_short_vectors();
    add_pair(elem_t'(3), elem_t'(4));
    add_pair(elem_t'(4), elem_t'(3));
    send_vectors();
    // orthogonal
    add_pair(elem_t'(1), elem_t'(0));
    add_pair(elem_t'(0), elem_t'(1));
    send_vectors();
    // first vector all zero
    add_pair(elem_t'(0), elem_t'(5));
    add_pair(elem_t'(0), elem_t'(-5));
    add_pair(elem_t'(0), elem_t'(7));
    send_vectors();
    // exactly opposite
    add_pair(elem_t'(2), elem_t'(-2));
    add_pair(elem_t'(-2), elem_t'(2));
    add_pair(elem_t'(2), elem_t'(-2));
    add_pair(elem_t'(-2), elem_t'(2));
    send_vectors();
    wait_for_results();
    add_pair(elem_t'(100), elem_t'(-7));
    add_pair(elem_t'(-3), elem_t'(250));
    send_vectors();
  endtask

  task automatic test_random_vectors(int n_words, int s_idle, int r_idle);
    int    sent;
    int    len;
    int    kind;
    elem_t v;
    elem_t w;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    sent = 0;
    while (sent < n_words) begin
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
      kind = $urandom_range(0, 9);
      for (int i = 0; i < len; i++) begin
        v = random_element(0);
        case (kind)
          3: w = v;
          4: w = -v;
          5: begin
            v = random_element(1);
            w = random_element(1);
          end
          6: begin
            w = random_element(0);
            if (i == 0 && $urandom_range(0, 1) == 1) begin
              v = w;
              w = '0;
            end else if (v_words.size() > 0 && v_words[0] == 0) begin
              v = '0;
            end else begin
              v = '0;
            end
          end
          7: begin
            v = random_element(2);
            w = random_element(2);
          end
          8: w = elem_t'(int'(v) + int'($urandom_range(0, 8)) - 4);
          9: begin
            v = random_element($urandom_range(0, 3));
            w = random_element($urandom_range(0, 3));
          end
          default: w = random_element(0);
        endcase
        add_pair(v, w);
      end
      // with a zero side picked at random, keep the whole side zero
      if (kind == 6 && v_words[0] != 0)
        foreach (w_words[i]) w_words[i] = '0;
      sent += len;
      send_vectors();
      if ($urandom_range(0, 11) == 0)
        wait_for_results();
    end
    wait_for_results();
  endtask

  // long vectors of extreme elements, pushing the sums far up their range
  task automatic test_large_sums();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 250; i++) add_pair(elem_t'(-32768), elem_t'(-32768));
    send_vectors();
    for (int i = 0; i < 250; i++) add_pair(elem_t'(-32768), elem_t'(32767));
    send_vectors();
    // large squares, dot stays near zero
    for (int i = 0; i < 100; i++)
      add_pair(elem_t'(-32768), (i % 2 == 0) ? elem_t'(32767) : elem_t'(-32767));
    send_vectors();
    wait_for_results();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 33;
    recv_idle_pct = 70;
    test_single_element_vectors();
    test_short_vectors();
    wait_for_results();

    test_random_vectors(420, 33, 70);
    test_random_vectors(420, 70, 33);
    test_random_vectors(410, 0, 0);
    test_large_sums();

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("streamed %0d vectors in %0d element words, %0d cosines compared",
             vectors_sent, words_sent, cosines_seen);
    $display("%0d zero-magnitude results, %0d at full scale, %0d mismatches",
             zero_results, full_scale, mismatches);
    if (mismatches == 0 && pending_cosines.size() == 0)
      $display("dense_cosine_similarity verification clean");
    else
      $display("dense_cosine_similarity verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/dcs_pkg.sv
hw/rtl/dcs_ctrl.sv
hw/rtl/dcs_datapath.sv
hw/rtl/dense_cosine_similarity.sv
hw/rtl/dcs_checker.sv
dv/tb_dense_cosine_similarity.sv
